@@ hdl/kle_pkg.sv @@
// ----------------------------------------------------------------------------
// kle_pkg
// Shared constants, types and command/status bundles for the keystroke line
// editor (gap buffer held in two stacks).
// ----------------------------------------------------------------------------
package kle_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int CHAR_W        = 8;

    localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd45;
    localparam logic [CHAR_W-1:0] KEY_LEFT      = 8'd60;
    localparam logic [CHAR_W-1:0] KEY_RIGHT     = 8'd62;

    localparam logic OP_KEY = 1'b0;
    localparam logic OP_EOL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE_L,
        ST_MOVE_R,
        ST_FL_READ,
        ST_FL_EMIT,
        ST_FL_EMPTY
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic push;        // insert key at cursor
        logic pop;         // backspace
        logic ovf_set;     // insert dropped, line full
        logic mvl_rd;      // cursor left: read top of left stack
        logic mvl_wr;      // cursor left: push read word onto right stack
        logic mvr_rd;      // cursor right: read top of right stack
        logic mvr_wr;      // cursor right: push read word onto left stack
        logic fl_start;    // flush: reset character index
        logic fl_read;     // flush: read character at index
        logic emit_char;   // flush: load output register with read character
        logic emit_empty;  // flush: load output register with empty marker
        logic clear;       // flush done: clear counts and overflow flag
    } kle_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_eol;
        logic is_bs;
        logic is_left;
        logic is_right;
        logic has_left;
        logic has_right;
        logic left_room;
        logic right_room;
        logic full;
        logic line_empty;
        logic last;
        logic out_free;
    } kle_sts_t;

endpackage

@@ hdl/kle_ram.sv @@
// ----------------------------------------------------------------------------
// kle_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/kle_datapath.sv @@
// ----------------------------------------------------------------------------
// kle_datapath
// Two stacks (left of cursor, right of cursor), their counts, the overflow
// flag, the flush index and the output register.
// ----------------------------------------------------------------------------
module kle_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kle_pkg::kle_cmd_t         cmd,
    output kle_pkg::kle_sts_t         sts,
    input  logic                      in_opcode,
    input  logic [kle_pkg::CHAR_W-1:0] in_key,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [kle_pkg::CHAR_W-1:0] out_char,
    output logic                      out_last,
    output logic                      out_empty,
    output logic                      out_dropped
);

    localparam int CW = kle_pkg::CNT_W;
    localparam int AW = kle_pkg::ADDR_W;
    localparam int DW = kle_pkg::CHAR_W;

    logic [CW-1:0] lc_reg, lc_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] k_reg, k_next;
    logic          sel_left_reg, sel_left_next;

    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_char_reg, out_char_next;
    logic          out_last_reg, out_last_next;
    logic          out_empty_reg, out_empty_next;
    logic          out_dropped_reg, out_dropped_next;

    logic [CW-1:0] total;
    logic [CW-1:0] lc_dec;
    logic [CW-1:0] rc_dec;
    logic [CW-1:0] r_flush_idx;

    logic          l_we, l_re, r_we, r_re;
    logic [AW-1:0] l_waddr, l_raddr, r_waddr, r_raddr;
    logic [DW-1:0] l_wdata, r_wdata, l_rdata, r_rdata;

    assign total       = lc_reg + rc_reg;
    assign lc_dec      = lc_reg - CW'(1);
    assign rc_dec      = rc_reg - CW'(1);
    assign r_flush_idx = total - k_reg - CW'(1);

    // Status toward the controller
    always_comb
    begin
        sts.is_eol     = (in_opcode == kle_pkg::OP_EOL);
        sts.is_bs      = (in_key == kle_pkg::KEY_BACKSPACE);
        sts.is_left    = (in_key == kle_pkg::KEY_LEFT);
        sts.is_right   = (in_key == kle_pkg::KEY_RIGHT);
        sts.has_left   = (lc_reg != '0);
        sts.has_right  = (rc_reg != '0);
        sts.left_room  = (lc_reg < CW'(kle_pkg::LINE_CAPACITY));
        sts.right_room = (rc_reg < CW'(kle_pkg::LINE_CAPACITY));
        sts.full       = (total == CW'(kle_pkg::LINE_CAPACITY));
        sts.line_empty = (total == '0);
        sts.last       = ((k_reg + CW'(1)) == total);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Stack port steering
    always_comb
    begin
        l_we    = cmd.push || cmd.mvr_wr;
        l_waddr = lc_reg[AW-1:0];
        l_wdata = cmd.mvr_wr ? r_rdata : in_key;
        l_re    = cmd.mvl_rd || (cmd.fl_read && (k_reg < lc_reg));
        l_raddr = cmd.mvl_rd ? lc_dec[AW-1:0] : k_reg[AW-1:0];

        r_we    = cmd.mvl_wr;
        r_waddr = rc_reg[AW-1:0];
        r_wdata = l_rdata;
        r_re    = cmd.mvr_rd || (cmd.fl_read && (k_reg >= lc_reg));
        r_raddr = cmd.mvr_rd ? rc_dec[AW-1:0] : r_flush_idx[AW-1:0];
    end

    kle_ram #(
        .WIDTH (DW),
        .DEPTH (kle_pkg::LINE_CAPACITY)
    ) u_left_stack (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    kle_ram #(
        .WIDTH (DW),
        .DEPTH (kle_pkg::LINE_CAPACITY)
    ) u_right_stack (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // Counts, overflow flag and flush index
    always_comb
    begin
        lc_next       = lc_reg;
        rc_next       = rc_reg;
        ovf_next      = ovf_reg;
        k_next        = k_reg;
        sel_left_next = sel_left_reg;

        if (cmd.push || cmd.mvr_wr)
        begin
            lc_next = lc_reg + CW'(1);
        end
        if (cmd.pop || cmd.mvl_wr)
        begin
            lc_next = lc_dec;
        end
        if (cmd.mvl_wr)
        begin
            rc_next = rc_reg + CW'(1);
        end
        if (cmd.mvr_wr)
        begin
            rc_next = rc_dec;
        end
        if (cmd.ovf_set)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.fl_start)
        begin
            k_next = '0;
        end
        if (cmd.fl_read)
        begin
            sel_left_next = (k_reg < lc_reg);
        end
        if (cmd.emit_char)
        begin
            k_next = k_reg + CW'(1);
        end
        if (cmd.clear)
        begin
            lc_next  = '0;
            rc_next  = '0;
            ovf_next = 1'b0;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ready;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        out_empty_next   = out_empty_reg;
        out_dropped_next = out_dropped_reg;
        if (cmd.emit_char)
        begin
            out_valid_next   = 1'b1;
            out_char_next    = sel_left_reg ? l_rdata : r_rdata;
            out_last_next    = sts.last;
            out_empty_next   = 1'b0;
            out_dropped_next = ovf_reg;
        end
        else if (cmd.emit_empty)
        begin
            out_valid_next   = 1'b1;
            out_char_next    = '0;
            out_last_next    = 1'b1;
            out_empty_next   = 1'b1;
            out_dropped_next = ovf_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg        <= '0;
            rc_reg        <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lc_reg        <= lc_next;
            rc_reg        <= rc_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sel_left_reg    <= sel_left_next;
        out_char_reg    <= out_char_next;
        out_last_reg    <= out_last_next;
        out_empty_reg   <= out_empty_next;
        out_dropped_reg <= out_dropped_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign out_last    = out_last_reg;
    assign out_empty   = out_empty_reg;
    assign out_dropped = out_dropped_reg;

    // Line never grows past capacity
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, lc_reg} + {1'b0, rc_reg}) <= (CW + 1)'(kle_pkg::LINE_CAPACITY))
        else $error("line length exceeds capacity");

    // A flush leaves an empty line and a cleared overflow flag
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (lc_reg == '0) && (rc_reg == '0) && !ovf_reg)
        else $error("line not cleared after flush");

    // Never overwrite a word still waiting downstream
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_char || cmd.emit_empty) |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while stalled");

endmodule

@@ hdl/kle_ctrl.sv @@
// ----------------------------------------------------------------------------
// kle_ctrl
// Sequencer for keystroke edits, cursor moves and line flush.
// ----------------------------------------------------------------------------
module kle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kle_pkg::kle_sts_t sts,
    output kle_pkg::kle_cmd_t cmd
);

    kle_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kle_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kle_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (sts.is_eol)
                    begin
                        state_next = sts.line_empty ? kle_pkg::ST_FL_EMPTY
                                                    : kle_pkg::ST_FL_READ;
                    end
                    else if (sts.is_left && sts.has_left && sts.right_room)
                    begin
                        state_next = kle_pkg::ST_MOVE_L;
                    end
                    else if (sts.is_right && sts.has_right && sts.left_room)
                    begin
                        state_next = kle_pkg::ST_MOVE_R;
                    end
                    else
                    begin
                        state_next = kle_pkg::ST_IDLE;
                    end
                end
            end
            kle_pkg::ST_MOVE_L,
            kle_pkg::ST_MOVE_R:
            begin
                state_next = kle_pkg::ST_IDLE;
            end
            kle_pkg::ST_FL_READ:
            begin
                state_next = kle_pkg::ST_FL_EMIT;
            end
            kle_pkg::ST_FL_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.last ? kle_pkg::ST_IDLE : kle_pkg::ST_FL_READ;
                end
            end
            kle_pkg::ST_FL_EMPTY:
            begin
                if (sts.out_free)
                begin
                    state_next = kle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kle_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            kle_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    priority if (sts.is_eol)
                    begin
                        cmd.fl_start = 1'b1;
                    end
                    else if (sts.is_bs)
                    begin
                        cmd.pop = sts.has_left;
                    end
                    else if (sts.is_left)
                    begin
                        cmd.mvl_rd = sts.has_left && sts.right_room;
                    end
                    else if (sts.is_right)
                    begin
                        cmd.mvr_rd = sts.has_right && sts.left_room;
                    end
                    else
                    begin
                        cmd.push    = !sts.full;
                        cmd.ovf_set = sts.full;
                    end
                end
            end
            kle_pkg::ST_MOVE_L:
            begin
                cmd.mvl_wr = 1'b1;
            end
            kle_pkg::ST_MOVE_R:
            begin
                cmd.mvr_wr = 1'b1;
            end
            kle_pkg::ST_FL_READ:
            begin
                cmd.fl_read = 1'b1;
            end
            kle_pkg::ST_FL_EMIT:
            begin
                cmd.emit_char = sts.out_free;
                cmd.clear     = sts.out_free && sts.last;
            end
            kle_pkg::ST_FL_EMPTY:
            begin
                cmd.emit_empty = sts.out_free;
                cmd.clear      = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A cursor move always follows an accepted word
    a_move_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kle_pkg::ST_MOVE_L || state_reg == kle_pkg::ST_MOVE_R)
        |-> $past(state_reg) == kle_pkg::ST_IDLE)
        else $error("cursor move entered without an accepted word");

endmodule

@@ hdl/keystroke_line_editor.sv @@
// Edits: an edit key is written as it is accepted; a cursor move reads the top of one stack,
//   then pushes that word onto the other. Flush: per character a registered stack read, then
//   an output load, plus any downstream stall; an empty line loads a single empty marker.
//   Input is held off during a cursor move and during a flush. Reset (rst_n low, async)
//   empties the line; stacks are not cleared.
// ----------------------------------------------------------------------------
// keystroke_line_editor
// Line editor on a gap buffer of two stacks, driven by keystroke bytes;
// an end-of-line word streams the line out and clears it.
// ----------------------------------------------------------------------------
module keystroke_line_editor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] key_code
    input  logic       s_tuser,   // [0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] text_char
    output logic       m_tlast,   // is_last
    output logic [1:0] m_tuser    // [0] is_empty, [1] dropped_insert
);

    kle_pkg::kle_cmd_t cmd;
    kle_pkg::kle_sts_t sts;
    logic              out_empty;
    logic              out_dropped;

    kle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kle_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_opcode   (s_tuser),
        .in_key      (s_tdata),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_char    (m_tdata),
        .out_last    (m_tlast),
        .out_empty   (out_empty),
        .out_dropped (out_dropped)
    );

    assign m_tuser = {out_dropped, out_empty};

endmodule
